// ===== hw/rtl/accpwm_pkg.sv =====
// shared types and constants for the accumulator pwm led driver
package accpwm_pkg;

  localparam int CHANNELS_DEF = 48;
  localparam int CHAN_W       = 6;
  localparam int LEVEL_W      = 9;
  localparam int PHASE_W      = 8;

  localparam logic [LEVEL_W-1:0] FULL_STEP = 9'h100;

  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic               func;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
  } in_t;

  typedef struct packed {
    logic              pin_level;
    logic [CHAN_W-1:0] out_channel;
    logic              latch;
  } out_t;

endpackage

// ===== hw/rtl/accumulator_pwm_serial_led_driver_core.sv =====
// Accumulator PWM LED driver. A set word (func 0) stores one channel's step (0..256, larger
// values clamp to 256) and gives no result. A tick word (func 1) walks the channels
// 0..CHANNELS-1: for each it adds the step to the 8-bit phase, returns the carry as pin_level
// and writes the low byte back. A tick keeps the block busy: it first primes the memory
// read, then handles one channel per cycle while the output is not stalled, paced by the
// single read port of the step and phase memories. The last result of a frame carries latch.
// Both memories read as zero after reset until written.
module accumulator_pwm_serial_led_driver_core #(
  parameter int CHANNELS = accpwm_pkg::CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  accpwm_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output accpwm_pkg::out_t out_word
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  accpwm_pkg::out_t out_word_r, out_word_nxt;
  logic [CHANNELS-1:0] step_vld_r, step_vld_nxt;
  logic [CHANNELS-1:0] phase_vld_r, phase_vld_nxt;

  // memories with registered read
  logic [accpwm_pkg::LEVEL_W-1:0] step_mem  [CHANNELS];
  logic [accpwm_pkg::PHASE_W-1:0] phase_mem [CHANNELS];
  logic [accpwm_pkg::LEVEL_W-1:0] rd_step_r;
  logic [accpwm_pkg::PHASE_W-1:0] rd_phase_r;
  logic                           rd_step_vld_r;
  logic                           rd_phase_vld_r;

  logic                           in_fire;
  logic                           set_en;
  logic [accpwm_pkg::LEVEL_W-1:0] set_level;
  logic [IDX_W-1:0]               set_idx;
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  logic                           ph_we;
  logic [accpwm_pkg::LEVEL_W-1:0] cur_step;
  logic [accpwm_pkg::PHASE_W-1:0] cur_phase;
  logic [accpwm_pkg::LEVEL_W:0]   sum;
  logic                           out_free;
  logic                           last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || out_ready;
  assign last      = (idx_r == IDX_W'(CHANNELS - 1));

  assign set_en    = in_fire && (in_data.func == accpwm_pkg::FUNC_SET) &&
                     ({1'b0, in_data.channel} < 7'(CHANNELS));
  assign set_idx   = IDX_W'(in_data.channel);
  assign set_level = (in_data.level > accpwm_pkg::FULL_STEP) ? accpwm_pkg::FULL_STEP
                                                             : in_data.level;

  // entries never written read as zero
  assign cur_step  = rd_step_vld_r  ? rd_step_r  : '0;
  assign cur_phase = rd_phase_vld_r ? rd_phase_r : '0;
  assign sum       = {1'b0, cur_step} + {2'b00, cur_phase};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    step_vld_nxt  = step_vld_r;
    phase_vld_nxt = phase_vld_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    ph_we         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (set_en) begin
      step_vld_nxt[set_idx] = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.func == accpwm_pkg::FUNC_TICK)) begin
          idx_nxt   = '0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          ph_we                    = 1'b1;
          phase_vld_nxt[idx_r]     = 1'b1;
          out_valid_nxt            = 1'b1;
          out_word_nxt.pin_level   = sum[accpwm_pkg::LEVEL_W-1] | sum[accpwm_pkg::LEVEL_W];
          out_word_nxt.out_channel = accpwm_pkg::CHAN_W'(idx_r);
          out_word_nxt.latch       = last;
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      step_vld_r  <= '0;
      phase_vld_r <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      step_vld_r  <= step_vld_nxt;
      phase_vld_r <= phase_vld_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (set_en) begin
      step_mem[set_idx] <= set_level;
    end
    if (ph_we) begin
      phase_mem[idx_r] <= sum[accpwm_pkg::PHASE_W-1:0];
    end
    if (rd_en) begin
      rd_step_r      <= step_mem[rd_addr];
      rd_phase_r     <= phase_mem[rd_addr];
      rd_step_vld_r  <= step_vld_r[rd_addr];
      rd_phase_vld_r <= phase_vld_r[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/accpwm_checker.sv =====
// port-level checks for the accumulator pwm led driver, bound to the top level
module accpwm_checker #(
  parameter int CHANNELS = accpwm_pkg::CHANNELS_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input accpwm_pkg::in_t  in_data,
  input logic             out_valid,
  input logic             out_ready,
  input accpwm_pkg::out_t out_word
);

  // a tick word makes the block busy
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.func == accpwm_pkg::FUNC_TICK)) |=> !in_ready)
    else $error("block ready right after a tick word");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed");

  // latch only on the last channel of a frame
  a_latch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.latch) |->
      (out_word.out_channel == accpwm_pkg::CHAN_W'(CHANNELS - 1)))
    else $error("latch on a channel other than the last");

  // inside a frame the next word follows at once when the receiver takes one
  a_frame_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_word.latch) |=> out_valid)
    else $error("gap inside a frame with the receiver ready");

  // while idle only the final word of a frame may be pending
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_word.latch)
    else $error("mid-frame word pending while idle");

endmodule

bind accumulator_pwm_serial_led_driver_core accpwm_checker #(.CHANNELS(CHANNELS)) u_accpwm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
